// ===== hw/rtl/text_terminal_char_output_unit_defines.svh =====
// Assertion helpers; the enclosing module provides clk and rst_n.
`ifndef TEXT_TERMINAL_CHAR_OUTPUT_UNIT_DEFINES_SVH
`define TEXT_TERMINAL_CHAR_OUTPUT_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, expr, msg)
`define ASSERT_IMPLIES(lbl, ante, cons, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== hw/rtl/ttco_pkg.sv =====
package ttco_pkg;

  localparam int NUM_COLS = 80;
  localparam int NUM_ROWS = 60;

  localparam int CHAR_W   = 8;
  localparam int COLOUR_W = 8;
  localparam int COL_W    = 7;
  localparam int ROW_W    = 6;
  localparam int CELLS    = NUM_COLS * NUM_ROWS;
  localparam int ADDR_W   = $clog2(CELLS);
  localparam int CELL_W   = CHAR_W + 2 * COLOUR_W;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 40;
  localparam int OUT_PAD_W  = OUT_DATA_W - CELL_W - COL_W - ROW_W;

  localparam logic [COL_W:0] COL_LIM = (COL_W + 1)'(NUM_COLS);
  localparam logic [ROW_W:0] ROW_LIM = (ROW_W + 1)'(NUM_ROWS);

  localparam logic [COLOUR_W-1:0] FG_RESET = 8'd14;
  localparam logic [COLOUR_W-1:0] BG_RESET = 8'd6;

  localparam logic [CHAR_W-1:0] CODE_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CODE_BS    = 8'd8;
  localparam logic [CHAR_W-1:0] CODE_LF    = 8'd10;
  localparam logic [CHAR_W-1:0] CODE_FF    = 8'd12;
  localparam logic [CHAR_W-1:0] CODE_CR    = 8'd13;

  localparam logic OP_PUT  = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic CFG_FG = 1'b0;
  localparam logic CFG_BG = 1'b1;

  typedef enum logic [2:0] {
    K_NOP,
    K_PRINT,
    K_NL,
    K_BS,
    K_FF,
    K_READ,
    K_READ_OOR
  } kind_t;

  typedef struct packed {
    logic load_item;
    logic calc_phys;
    logic clear_start;
    logic calc_addr;
    logic wr_print;
    logic next_line;
    logic sweep_wr;
    logic sweep_init;
    logic top_inc;
    logic rd_done;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  wrap;
    logic  row_last;
    logic  sweep_last;
    logic  out_free;
  } stat_t;

endpackage

// ===== hw/rtl/ttco_ram.sv =====
module ttco_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4800
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/ttco_ctrl.sv =====
`include "text_terminal_char_output_unit_defines.svh"

module ttco_ctrl import ttco_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_tvalid,
  output logic  in_tready,
  input  stat_t st,
  output cmd_t  cmd
);

  typedef enum logic [10:0] {
    ST_INIT   = 11'b000_0000_0001,
    ST_IDLE   = 11'b000_0000_0010,
    ST_PHYS   = 11'b000_0000_0100,
    ST_ADDR   = 11'b000_0000_1000,
    ST_WRITE  = 11'b000_0001_0000,
    ST_LINE   = 11'b000_0010_0000,
    ST_SCROLL = 11'b000_0100_0000,
    ST_CLEAR  = 11'b000_1000_0000,
    ST_READ   = 11'b001_0000_0000,
    ST_RWAIT  = 11'b010_0000_0000,
    ST_DONE   = 11'b100_0000_0000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    state_nxt = state_r;
    case (state_r)
      ST_INIT: begin
        cmd.sweep_wr   = 1'b1;
        cmd.sweep_init = 1'b1;
        if (st.sweep_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load_item = 1'b1;
          state_nxt     = ST_PHYS;
        end
      end
      ST_PHYS: begin
        cmd.calc_phys = 1'b1;
        case (st.kind)
          K_PRINT, K_BS, K_READ: state_nxt = ST_ADDR;
          K_NL:                  state_nxt = ST_LINE;
          K_FF: begin
            cmd.clear_start = 1'b1;
            state_nxt       = ST_CLEAR;
          end
          default:               state_nxt = ST_DONE;
        endcase
      end
      ST_ADDR: begin
        cmd.calc_addr = 1'b1;
        state_nxt     = (st.kind == K_PRINT) ? ST_WRITE : ST_READ;
      end
      ST_WRITE: begin
        cmd.wr_print = 1'b1;
        state_nxt    = st.wrap ? ST_LINE : ST_DONE;
      end
      ST_LINE: begin
        cmd.next_line = 1'b1;
        state_nxt     = st.row_last ? ST_SCROLL : ST_DONE;
      end
      ST_SCROLL: begin
        cmd.sweep_wr = 1'b1;
        if (st.sweep_last) begin
          cmd.top_inc = 1'b1;
          state_nxt   = ST_DONE;
        end
      end
      ST_CLEAR: begin
        cmd.sweep_wr = 1'b1;
        if (st.sweep_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_READ: begin
        // RAM read address settles here; data lands next cycle
        state_nxt = ST_RWAIT;
      end
      ST_RWAIT: begin
        cmd.rd_done = 1'b1;
        state_nxt   = ST_DONE;
      end
      ST_DONE: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  // every item passes through work states before the next can enter
  `ASSERT_NEXT(a_one_item_at_a_time, in_tvalid && in_tready, !in_tready,
               "input taken on two consecutive cycles")
  `ASSERT_IMPLIES(a_sweep_only_when_clearing, cmd.sweep_wr,
                  state_r == ST_INIT || state_r == ST_SCROLL || state_r == ST_CLEAR,
                  "cell sweep outside a clearing state")

endmodule

// ===== hw/rtl/ttco_dp.sv =====
`include "text_terminal_char_output_unit_defines.svh"

module ttco_dp import ttco_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tuser,
  input  logic                  cfg_valid,
  input  logic                  cfg_index,
  input  logic [COLOUR_W-1:0]   cfg_data,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  cmd_t                  cmd,
  output stat_t                 st
);

  logic [COLOUR_W-1:0]   fg_r;
  logic [COLOUR_W-1:0]   bg_r;
  logic                  op_r;
  logic [CHAR_W-1:0]     ch_r;
  logic [COL_W-1:0]      rc_r;
  logic [ROW_W-1:0]      rr_r;
  logic [COL_W-1:0]      col_r;
  logic [ROW_W-1:0]      row_r;
  logic [ROW_W-1:0]      top_r;
  logic [ROW_W-1:0]      phys_r;
  logic [ROW_W-1:0]      phys_nxt;
  logic [COL_W-1:0]      col_sel_r;
  logic [COL_W-1:0]      col_sel_nxt;
  logic [ADDR_W-1:0]     addr_r;
  logic [ADDR_W-1:0]     sweep_addr_r;
  logic [ADDR_W-1:0]     sweep_end_r;
  logic [ADDR_W-1:0]     scroll_base;
  logic [CELL_W-1:0]     cell_r;
  logic                  out_tvalid_r;
  logic [OUT_DATA_W-1:0] out_tdata_r;

  kind_t               kind;
  logic [ROW_W-1:0]    row_sel;
  logic [ROW_W:0]      row_sum;
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [CELL_W-1:0]   ram_wdata;
  logic [CELL_W-1:0]   ram_rdata;

  // item class
  always_comb begin
    if (op_r == OP_READ) begin
      kind = ({1'b0, rc_r} < COL_LIM && {1'b0, rr_r} < ROW_LIM) ? K_READ : K_READ_OOR;
    end else begin
      case (ch_r)
        CODE_CR, CODE_LF: kind = K_NL;
        CODE_BS:          kind = (col_r != '0) ? K_BS : K_NOP;
        CODE_FF:          kind = K_FF;
        default:          kind = (ch_r >= CODE_SPACE) ? K_PRINT : K_NOP;
      endcase
    end
  end

  // displayed row to stored row: the ring starts at top_r
  always_comb begin
    row_sel  = (op_r == OP_READ) ? rr_r : row_r;
    row_sum  = {1'b0, row_sel} + {1'b0, top_r};
    phys_nxt = (row_sum >= ROW_LIM) ? ROW_W'(row_sum - ROW_LIM) : row_sum[ROW_W-1:0];
    if (op_r == OP_READ) begin
      col_sel_nxt = rc_r;
    end else if (kind == K_BS) begin
      col_sel_nxt = col_r - COL_W'(1);
    end else begin
      col_sel_nxt = col_r;
    end
  end

  assign scroll_base = ADDR_W'(top_r) * ADDR_W'(NUM_COLS);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr_r;
    ram_wdata = {ch_r, fg_r, bg_r};
    if (cmd.sweep_wr) begin
      ram_we    = 1'b1;
      ram_waddr = sweep_addr_r;
      ram_wdata = cmd.sweep_init ? {CODE_SPACE, FG_RESET, BG_RESET}
                                 : {CODE_SPACE, fg_r, bg_r};
    end else if (cmd.wr_print) begin
      ram_we = 1'b1;
    end else if (cmd.rd_done && kind == K_BS) begin
      // backspace keeps the cell colours
      ram_we    = 1'b1;
      ram_wdata = {CODE_SPACE, ram_rdata[2*COLOUR_W-1:0]};
    end
  end

  ttco_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (addr_r),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fg_r         <= FG_RESET;
      bg_r         <= BG_RESET;
      col_r        <= '0;
      row_r        <= '0;
      top_r        <= '0;
      sweep_addr_r <= '0;
      sweep_end_r  <= ADDR_W'(CELLS - 1);
      out_tvalid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_FG:  fg_r <= cfg_data;
          CFG_BG:  bg_r <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.wr_print) begin
        col_r <= st.wrap ? '0 : col_r + COL_W'(1);
      end
      if (cmd.next_line) begin
        col_r <= '0;
        if (st.row_last) begin
          sweep_addr_r <= scroll_base;
          sweep_end_r  <= scroll_base + ADDR_W'(NUM_COLS - 1);
        end else begin
          row_r <= row_r + ROW_W'(1);
        end
      end
      if (cmd.clear_start) begin
        sweep_addr_r <= '0;
        sweep_end_r  <= ADDR_W'(CELLS - 1);
        top_r        <= '0;
        col_r        <= '0;
        row_r        <= '0;
      end
      if (cmd.sweep_wr) begin
        sweep_addr_r <= sweep_addr_r + ADDR_W'(1);
      end
      if (cmd.top_inc) begin
        top_r <= (top_r == ROW_W'(NUM_ROWS - 1)) ? '0 : top_r + ROW_W'(1);
      end
      if (cmd.rd_done && kind == K_BS) begin
        col_r <= col_sel_r;
      end
      if (cmd.out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op_r   <= in_tuser;
      ch_r   <= in_tdata[CHAR_W-1:0];
      rc_r   <= in_tdata[CHAR_W +: COL_W];
      rr_r   <= in_tdata[CHAR_W + COL_W +: ROW_W];
      cell_r <= '0;
    end
    if (cmd.calc_phys) begin
      phys_r    <= phys_nxt;
      col_sel_r <= col_sel_nxt;
    end
    if (cmd.calc_addr) begin
      addr_r <= ADDR_W'(phys_r) * ADDR_W'(NUM_COLS) + ADDR_W'(col_sel_r);
    end
    if (cmd.rd_done && kind == K_READ) begin
      cell_r <= ram_rdata;
    end
    if (cmd.out_load) begin
      out_tdata_r <= {{OUT_PAD_W{1'b0}}, row_r, col_r,
                      cell_r[COLOUR_W-1:0],
                      cell_r[2*COLOUR_W-1:COLOUR_W],
                      cell_r[CELL_W-1:2*COLOUR_W]};
    end
  end

  assign st.kind       = kind;
  assign st.wrap       = (col_r == COL_W'(NUM_COLS - 1));
  assign st.row_last   = (row_r == ROW_W'(NUM_ROWS - 1));
  assign st.sweep_last = (sweep_addr_r == sweep_end_r);
  assign st.out_free   = !out_tvalid_r || out_tready;

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  `ASSERT_ALWAYS(a_cursor_in_grid, (({1'b0, col_r} < COL_LIM) && ({1'b0, row_r} < ROW_LIM)),
                 "cursor outside the grid")
  `ASSERT_ALWAYS(a_top_in_ring, ({1'b0, top_r} < ROW_LIM), "scroll offset out of range")
  `ASSERT_IMPLIES(a_sweep_in_bounds, cmd.sweep_wr, sweep_addr_r <= sweep_end_r,
                  "sweep ran past its last cell")

endmodule

// ===== hw/rtl/text_terminal_char_output_unit.sv =====
// Text terminal over an 80 x 60 cell store (character, foreground, background).
// Input stream: in_tuser selects the operation (0 = put character, 1 = read a
// cell); in_tdata carries the character and the cell to read. Each item gives
// exactly one result on the output stream: the read cell (zero for a put, or
// for a read outside the grid) and the cursor after the item.
// Config channel: cfg_index 0 sets the foreground, 1 the background colour;
// always ready, write only while no item is in flight.
// From acceptance to result valid an item steps through control states, then
// returns to idle before the next acceptance: plain character phys, addr,
// write; CR/LF phys, line; backspace and read phys, addr, read, read wait;
// ignored code, backspace in column 0 and a read outside the grid phys only.
// A wrap at the end of a row adds the line step. A line feed or wrap on the
// last row also scrolls: the old top row is blanked one cell per cycle through
// the single write port. Form feed blanks all 4800 cells the same way.
// After reset the store is cleared to spaces in colours 14/6 the same way,
// while in_tready stays low; config writes are taken meanwhile.
// The result sits in an output register; while out_tready is low the block
// takes and works on the next item, and holds its result until the register
// frees.
module text_terminal_char_output_unit import ttco_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // ch[7:0], read_col[14:8], read_row[20:15]
  input  logic                  in_tuser,   // op
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // cell_char[7:0], cell_fg[15:8],
                                            // cell_bg[23:16], cursor_col[30:24],
                                            // cursor_row[36:31]
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic                  cfg_index,
  input  logic [COLOUR_W-1:0]   cfg_data
);

  cmd_t  cmd;
  stat_t st;

  assign cfg_ready = 1'b1;

  ttco_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  ttco_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cmd        (cmd),
    .st         (st)
  );

endmodule

// ===== bench/tb_text_terminal_char_output_unit.sv =====
module tb_text_terminal_char_output_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import ttco_pkg::*;

  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 12;

  typedef struct packed {
    logic [CHAR_W-1:0]   chr;
    logic [COLOUR_W-1:0] fg;
    logic [COLOUR_W-1:0] bg;
  } cell_t;

  typedef struct packed {
    logic [CHAR_W-1:0]   chr;
    logic [COLOUR_W-1:0] fg;
    logic [COLOUR_W-1:0] bg;
    logic [COL_W-1:0]    col;
    logic [ROW_W-1:0]    row;
  } report_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic                  cfg_index = 1'b0;
  logic [COLOUR_W-1:0]   cfg_data = '0;

  // shadow of the terminal
  cell_t               shadow_screen [CELLS];
  int                  cur_col;
  int                  cur_row;
  int                  top_row;
  logic [COLOUR_W-1:0] fg_now;
  logic [COLOUR_W-1:0] bg_now;

  report_t report_queue [$];
  int      errors = 0;
  bit      tx_idle_on = 1'b1;
  bit      rx_idle_on = 1'b1;
  int      hold_reqs = 0;
  int      hold_served = 0;
  int      hold_left = 0;

  text_terminal_char_output_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #8_000_000;
    $display("Verification failed");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic int cell_at(input int col, input int row);
    return ((row + top_row) % NUM_ROWS) * NUM_COLS + col;
  endfunction

  function automatic void blank_screen();
    for (int i = 0; i < CELLS; i++) shadow_screen[i] = '{CODE_SPACE, fg_now, bg_now};
  endfunction

  function automatic void new_line();
    cur_col = 0;
    if (cur_row + 1 >= NUM_ROWS) begin
      // old top row is recycled as the blank bottom row
      for (int i = 0; i < NUM_COLS; i++)
        shadow_screen[top_row * NUM_COLS + i] = '{CODE_SPACE, fg_now, bg_now};
      top_row = (top_row + 1) % NUM_ROWS;
    end else begin
      cur_row++;
    end
  endfunction

  function automatic report_t screen_step(input logic op, input logic [CHAR_W-1:0] ch,
                                          input logic [COL_W-1:0] rc,
                                          input logic [ROW_W-1:0] rr);
    report_t rep;
    cell_t   c;
    int      idx;
    rep = '0;
    if (op == OP_READ) begin
      if (rc < NUM_COLS && rr < NUM_ROWS) begin
        c = shadow_screen[cell_at(rc, rr)];
        rep.chr = c.chr;
        rep.fg  = c.fg;
        rep.bg  = c.bg;
      end
    end else if (ch == CODE_CR || ch == CODE_LF) begin
      new_line();
    end else if (ch == CODE_BS) begin
      if (cur_col != 0) begin
        cur_col--;
        idx = cell_at(cur_col, cur_row);
        shadow_screen[idx].chr = CODE_SPACE;
      end
    end else if (ch == CODE_FF) begin
      blank_screen();
      top_row = 0;
      cur_col = 0;
      cur_row = 0;
    end else if (ch >= CODE_SPACE) begin
      shadow_screen[cell_at(cur_col, cur_row)] = '{ch, fg_now, bg_now};
      cur_col++;
      if (cur_col >= NUM_COLS) new_line();
    end
    rep.col = COL_W'(cur_col);
    rep.row = ROW_W'(cur_row);
    return rep;
  endfunction

  // ---------------------------------------------------------------- checking

  function automatic void compare_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  function automatic void check_report(input logic [OUT_DATA_W-1:0] data);
    report_t want;
    if (report_queue.size() == 0) begin
      $error("unexpected result transfer: %h", data);
      errors++;
      return;
    end
    want = report_queue.pop_front();
    compare_field("cell_char", want.chr, data[7:0]);
    compare_field("cell_fg", want.fg, data[15:8]);
    compare_field("cell_bg", want.bg, data[23:16]);
    compare_field("cursor_col", 8'(want.col), 8'(data[30:24]));
    compare_field("cursor_row", 8'(want.row), 8'(data[36:31]));
  endfunction

  // result side: check first, then pick tready for the next edge
  always @(posedge clk) begin
    if (out_tvalid && out_tready) check_report(out_tdata);
    if (hold_served != hold_reqs) begin
      hold_left = HOLD_CYCLES;
      hold_served++;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= !(rx_idle_on && $urandom_range(99) < 6);
    end
  end

  // ---------------------------------------------------------------- drivers

  task automatic send_item(input logic op, input logic [CHAR_W-1:0] ch,
                           input logic [COL_W-1:0] rc, input logic [ROW_W-1:0] rr);
    if (tx_idle_on && $urandom_range(99) < 6) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {3'b000, rr, rc, ch};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    report_queue.push_back(screen_step(op, ch, rc, rr));
  endtask

  task automatic put_char(input logic [CHAR_W-1:0] ch);
    send_item(OP_PUT, ch, COL_W'($urandom), ROW_W'($urandom));
  endtask

  task automatic read_cell(input int col, input int row);
    send_item(OP_READ, CHAR_W'($urandom), COL_W'(col), ROW_W'(row));
  endtask

  function automatic logic [CHAR_W-1:0] printable();
    return CHAR_W'($urandom_range(8'h20, 8'hFF));
  endfunction

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (report_queue.size() != 0) @(posedge clk);
    // quiet cycles to settle before the next register write
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [COLOUR_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_FG) fg_now = val;
    else bg_now = val;
  endtask

  task automatic set_colours(input logic [COLOUR_W-1:0] fg, input logic [COLOUR_W-1:0] bg);
    wait_drained();
    if ($urandom_range(1) == 1) begin
      write_reg(CFG_FG, fg);
      write_reg(CFG_BG, bg);
    end else begin
      write_reg(CFG_BG, bg);
      write_reg(CFG_FG, fg);
    end
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_directed();
    read_cell(0, 0);
    read_cell(NUM_COLS - 1, NUM_ROWS - 1);
    read_cell(NUM_COLS, 0);
    read_cell(0, NUM_ROWS);
    read_cell(127, 63);
    put_char(CODE_BS);              // backspace in column 0 does nothing
    put_char(8'h41);
    put_char(8'hFF);
    put_char(CODE_SPACE);
    put_char(8'h7F);
    put_char(8'h80);
    put_char(CODE_BS);
    read_cell(4, 0);
    read_cell(3, 0);
    put_char(8'h00);                // ignored control codes
    put_char(8'h1F);
    put_char(8'h07);
    put_char(CODE_CR);
    put_char(CODE_LF);
    put_char(8'h7A);
    put_char(CODE_FF);
    read_cell(0, 0);
    read_cell(0, 2);
  endtask

  task automatic test_colour_settings();
    logic [COLOUR_W-1:0] fgs [5];
    logic [COLOUR_W-1:0] bgs [5];
    fgs = '{8'h00, 8'hFF, 8'h00, 8'hFF, COLOUR_W'($urandom)};
    bgs = '{8'h00, 8'hFF, 8'hFF, 8'h00, COLOUR_W'($urandom)};
    for (int s = 0; s < 5; s++) begin
      set_colours(fgs[s], bgs[s]);
      if (s == 1 || s == 3) put_char(CODE_FF);
      repeat ($urandom_range(3, 8)) put_char(printable());
      put_char(CODE_BS);
      read_cell(cur_col, cur_row);
      read_cell(cur_col > 0 ? cur_col - 1 : 0, cur_row);
      read_cell($urandom_range(0, NUM_COLS - 1), $urandom_range(0, NUM_ROWS - 1));
      put_char(CODE_LF);
    end
  endtask

  task automatic test_scroll_and_wrap();
    set_colours(8'h5A, 8'hA5);
    put_char(CODE_FF);
    repeat (NUM_ROWS + 4) begin
      repeat ($urandom_range(0, 5)) put_char(printable());
      put_char(($urandom_range(1) == 1) ? CODE_LF : CODE_CR);
    end
    // full lines on the bottom row wrap and scroll by themselves
    repeat (2 * NUM_COLS) put_char(printable());
    put_char(CODE_LF);
    repeat (NUM_COLS + 3) put_char(printable());
    repeat (4) put_char(CODE_BS);
    for (int r = 0; r < NUM_ROWS; r += 3) read_cell($urandom_range(0, 4), r);
    read_cell(0, NUM_ROWS - 1);
    read_cell(NUM_COLS - 1, NUM_ROWS - 2);
  endtask

  task automatic test_random_traffic(input int n_items);
    int sent;
    int sel;
    int run;
    sent = 0;
    while (sent < n_items) begin
      sel = $urandom_range(99);
      if (sel < 50) begin
        run = ($urandom_range(9) == 0) ? $urandom_range(70, 100) : $urandom_range(1, 20);
        repeat (run) put_char(printable());
        sent += run;
      end else if (sel < 64) begin
        put_char(($urandom_range(1) == 1) ? CODE_LF : CODE_CR);
        sent++;
      end else if (sel < 70) begin
        put_char(CODE_BS);
        sent++;
      end else if (sel < 80) begin
        // recent text on the cursor row
        read_cell($urandom_range(0, cur_col), cur_row);
        sent++;
      end else if (sel < 90) begin
        read_cell($urandom_range(0, NUM_COLS - 1), $urandom_range(0, NUM_ROWS - 1));
        sent++;
      end else if (sel < 99) begin
        // noise over the whole field ranges
        send_item(1'($urandom), CHAR_W'($urandom), COL_W'($urandom), ROW_W'($urandom));
        sent++;
      end else if ($urandom_range(3) == 0) begin
        put_char(CODE_FF);
        sent++;
      end
    end
  endtask

  task automatic test_output_stall();
    hold_reqs++;
    repeat (60) begin
      if ($urandom_range(3) == 0)
        read_cell($urandom_range(0, NUM_COLS - 1), $urandom_range(0, NUM_ROWS - 1));
      else
        put_char(printable());
    end
    // sender stays quiet until everything has come back
    wait_drained();
    repeat (40) put_char(printable());
  endtask

  initial begin
    fg_now  = FG_RESET;
    bg_now  = BG_RESET;
    cur_col = 0;
    cur_row = 0;
    top_row = 0;
    blank_screen();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_colour_settings();
    test_scroll_and_wrap();
    test_random_traffic(350);
    set_colours(COLOUR_W'($urandom), COLOUR_W'($urandom));
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    test_random_traffic(350);
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    test_output_stall();
    set_colours(8'hFF, 8'h00);
    test_random_traffic(350);
    set_colours(COLOUR_W'($urandom), COLOUR_W'($urandom));
    test_random_traffic(350);

    wait_drained();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
